### rtl/aedl_pkg.sv
// ----------------------------------------------------------------------------
// aedl_pkg
// Shared types and constants for the audio echo delay line.
// ----------------------------------------------------------------------------
package aedl_pkg;

  localparam int STORE_DEPTH_DEF = 16384;
  localparam int MAX_REPEATS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 32;
  localparam int FRAMES_W = 14;
  localparam int REPEAT_W = 5;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_ECHO = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

### rtl/audio_echo_delay_line_core.sv
// ----------------------------------------------------------------------------
// audio_echo_delay_line_core
// Circular sample store with push and echo-mix commands.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): a push stores a saturated 16-bit sample
// one place below the write pointer and gives no result; the next transaction
// may follow straight away. An echo starts at the write pointer and walks
// repeat_count taps (capped at MAX_REPEATS), each delay_frames further on,
// averaging each stored sample into the 16.16 dry value with truncation
// toward zero.
// Result channel (out_valid/out_stall): one transaction per echo, held in an
// output register, so the next command is taken while a result still waits.
// When STORE_DEPTH is below 16384 an extra ST_MOD step reduces the delay
// modulo the depth. The input opens again in the cycle out_valid rises.
// The single read port of the store sets the pace: one tap per cycle.
// Reset: the write pointer goes to the top of the store and a clearing pass
// zeroes the store; in_stall stays high meanwhile.
// A stalled result stalls only the finish of the following echo.
// ----------------------------------------------------------------------------
module audio_echo_delay_line_core #(
  parameter int STORE_DEPTH = aedl_pkg::STORE_DEPTH_DEF,
  parameter int MAX_REPEATS = aedl_pkg::MAX_REPEATS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [aedl_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [aedl_pkg::FRAMES_W-1:0]       in_delay_frames,
  input  logic [aedl_pkg::REPEAT_W-1:0]       in_repeat_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [aedl_pkg::VALUE_W-1:0] out_mixed_value
);

  localparam int PW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RW  = $clog2(MAX_REPEATS + 1);
  localparam int FW  = aedl_pkg::FRAMES_W;
  localparam int SW  = aedl_pkg::SAMPLE_W;
  localparam int VW  = aedl_pkg::VALUE_W;
  localparam int PRW = 2 * FW + 1;
  localparam int RSH = FW + PW;
  localparam longint RECIP =
    ((longint'(1) <<< RSH) + longint'(STORE_DEPTH) - 1) / longint'(STORE_DEPTH);
  localparam logic [FW:0]   RECIP_K = (FW + 1)'(RECIP);
  localparam logic [FW-1:0] DEPTH_K = FW'(STORE_DEPTH);
  localparam bit NEED_MOD = (STORE_DEPTH < (2 ** aedl_pkg::FRAMES_W));
  localparam logic [PW-1:0] TOP_ADDR = PW'(STORE_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(STORE_DEPTH);

  aedl_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]        wp_r, wp_nxt;
  logic [PW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        frames_r, frames_nxt;
  logic [FW-1:0]        dly_r, dly_nxt;
  logic [FW-1:0]        quo_r, quo_nxt;
  logic [RW-1:0]        reps_r, reps_nxt;
  logic [RW-1:0]        iss_r, iss_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic signed [VW-1:0] acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic           accept;
  logic [PW-1:0]  wp_dec;
  logic [PW:0]    pos_sum;
  logic [PW-1:0]  pos_adv;
  logic [PRW-1:0] quo_prod;
  logic [FW-1:0]  quo_calc;
  logic [FW-1:0]  mod_prod;
  logic [PW-1:0]  mod_red;
  logic           issue;
  logic           out_load;
  logic           clr_last;
  logic [VW:0]    mix_sum;
  logic [VW-1:0]  mix_half;
  logic [RW-1:0]  reps_sat;
  logic [SW-1:0]  push_sample;

  function automatic logic [SW-1:0] sat16(input logic signed [VW-1:0] v);
    logic [SW-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'h7fff;
    end else if (v < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  aedl_ram #(
    .WIDTH (SW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared datapath pieces
  always_comb begin
    accept      = in_valid && !in_stall;
    wp_dec      = (wp_r == '0) ? TOP_ADDR : wp_r - 1'b1;
    push_sample = sat16(in_sample_value);

    // single wrap is enough: both operands are below the depth
    pos_sum = {1'b0, pos_r} + {1'b0, frames_r};
    pos_adv = (pos_sum >= DEPTH_W) ? PW'(pos_sum - DEPTH_W) : pos_sum[PW-1:0];

    // delay modulo the depth: quotient by reciprocal multiplication (exact for
    // every 14-bit delay), remainder by one multiply-subtract in ST_MOD
    quo_prod = PRW'(in_delay_frames) * PRW'(RECIP_K);
    quo_calc = FW'(quo_prod >> RSH);
    mod_prod = quo_r * DEPTH_K;
    mod_red  = PW'(dly_r - mod_prod);

    issue    = (state_r == aedl_pkg::ST_RUN) && (iss_r != reps_r);
    out_load = (state_r == aedl_pkg::ST_DONE) && (!out_valid_r || !out_stall);
    clr_last = (clr_addr_r == TOP_ADDR);

    // add tap scaled to 16.16, then halve rounding toward zero
    mix_sum  = {acc_r[VW-1], acc_r} + {ram_rdata[SW-1], ram_rdata, 16'h0000};
    mix_half = mix_sum[VW:1] + {{(VW-1){1'b0}}, mix_sum[VW] & mix_sum[0]};

    if (32'(in_repeat_count) > 32'(MAX_REPEATS)) begin
      reps_sat = RW'(MAX_REPEATS);
    end else begin
      reps_sat = RW'(in_repeat_count);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aedl_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = aedl_pkg::ST_IDLE;
      end
      aedl_pkg::ST_IDLE: begin
        if (accept && in_command == aedl_pkg::CMD_ECHO) begin
          state_nxt = NEED_MOD ? aedl_pkg::ST_MOD : aedl_pkg::ST_RUN;
        end
      end
      aedl_pkg::ST_MOD: begin
        state_nxt = aedl_pkg::ST_RUN;
      end
      aedl_pkg::ST_RUN: begin
        if (!issue && !rd_pend_r) state_nxt = aedl_pkg::ST_DONE;
      end
      aedl_pkg::ST_DONE: begin
        if (out_load) state_nxt = aedl_pkg::ST_IDLE;
      end
      default: state_nxt = aedl_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = wp_dec;
    ram_wdata     = push_sample;
    ram_raddr     = pos_adv;
    wp_nxt        = wp_r;
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    frames_nxt    = frames_r;
    dly_nxt       = dly_r;
    quo_nxt       = quo_r;
    reps_nxt      = reps_r;
    iss_nxt       = iss_r;
    acc_nxt       = acc_r;
    rd_pend_nxt   = issue;

    unique case (state_r)
      aedl_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      aedl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          if (in_command == aedl_pkg::CMD_PUSH) begin
            ram_we = 1'b1;
            wp_nxt = wp_dec;
          end else begin
            acc_nxt     = in_sample_value;
            pos_nxt     = wp_r;
            reps_nxt    = reps_sat;
            iss_nxt     = '0;
            dly_nxt     = in_delay_frames;
            quo_nxt     = quo_calc;
            frames_nxt  = NEED_MOD ? '0 : PW'(in_delay_frames);
          end
        end
      end
      aedl_pkg::ST_MOD: begin
        frames_nxt = mod_red;
      end
      aedl_pkg::ST_RUN: begin
        if (issue) begin
          pos_nxt = pos_adv;
          iss_nxt = iss_r + 1'b1;
        end
        if (rd_pend_r) begin
          acc_nxt = mix_half;
        end
      end
      aedl_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_value_nxt = out_load ? acc_r : out_value_r;
  end

  assign out_valid       = out_valid_r;
  assign out_mixed_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aedl_pkg::ST_CLEAR;
      wp_r        <= TOP_ADDR;
      clr_addr_r  <= '0;
      iss_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      clr_addr_r  <= clr_addr_nxt;
      iss_r       <= iss_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    frames_r    <= frames_nxt;
    dly_r       <= dly_nxt;
    quo_r       <= quo_nxt;
    reps_r      <= reps_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aedl_pkg::ST_RUN) |-> (pos_r <= TOP_ADDR && frames_r <= TOP_ADDR))
    else $error("read position or delay outside the store during echo");

  a_push_moves_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == aedl_pkg::CMD_PUSH) |=>
      (wp_r == (($past(wp_r) == '0) ? TOP_ADDR : $past(wp_r) - 1'b1)))
    else $error("write pointer did not step down on push");

  a_no_write_in_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aedl_pkg::ST_MOD || state_r == aedl_pkg::ST_RUN ||
     state_r == aedl_pkg::ST_DONE) |-> !ram_we)
    else $error("store written while an echo is in progress");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aedl_pkg::ST_RUN) |-> (iss_r <= reps_r))
    else $error("more taps read than requested");

endmodule

### rtl/aedl_ram.sv
// ----------------------------------------------------------------------------
// aedl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aedl_ram #(
  parameter int WIDTH = aedl_pkg::SAMPLE_W,
  parameter int DEPTH = aedl_pkg::STORE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
